/* hdl/dst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

  // coordinate limit applied to every box corner
  localparam logic [12:0] COORD_MAX = 13'd4096;

  // tick counter value on which the span is flushed
  localparam logic [1:0] TICK_LAST = 2'd3;

  // largest byte offset or length that fits the result fields
  localparam logic [26:0] OUT_MAX = '1;

  // request kinds
  localparam logic KIND_BOX  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // configuration register indexes
  localparam logic [0:0] REG_ROW_PITCH       = 1'd0;
  localparam logic [0:0] REG_BYTES_PER_PIXEL = 1'd1;

  // configuration reset values
  localparam logic [14:0] ROW_PITCH_RESET       = 15'd4096;
  localparam logic [2:0]  BYTES_PER_PIXEL_RESET = 3'd2;

  // input request
  typedef struct packed {
    logic        kind;
    logic [12:0] box_x1;
    logic [12:0] box_y1;
    logic [12:0] box_x2;
    logic [12:0] box_y2;
  } box_item_t;

  // flush result
  typedef struct packed {
    logic [26:0] start_offset;
    logic [26:0] span_length;
  } span_result_t;

  // span captured on a flushing tick, differences already formed
  typedef struct packed {
    logic [12:0]        start_x;
    logic [12:0]        start_y;
    logic signed [14:0] rows_m1;
    logic signed [13:0] cols;
  } span_snap_t;

endpackage

`default_nettype wire

/* hdl/dst_span_update.sv */
`timescale 1ns / 1ps
`default_nettype none

module dst_span_update (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire dst_pkg::box_item_t item,
  output logic                    item_retire,
  output logic                    snap_valid,
  input  wire logic               snap_take,
  output dst_pkg::span_snap_t     snap
);

  logic [12:0] start_x;
  logic [12:0] start_y;
  logic [12:0] end_x;
  logic [12:0] end_y;
  logic        damage_pending;
  logic [1:0]  tick_count;

  logic [12:0] x1_c;
  logic [12:0] y1_c;
  logic [12:0] x2_c;
  logic [12:0] y2_c;
  logic        emits;

  function automatic logic [12:0] clamp_coord(input logic [12:0] v);
    clamp_coord = (v > dst_pkg::COORD_MAX) ? dst_pkg::COORD_MAX : v;
  endfunction

  // clamped box corners
  assign x1_c = clamp_coord(item.box_x1);
  assign y1_c = clamp_coord(item.box_y1);
  assign x2_c = clamp_coord(item.box_x2);
  assign y2_c = clamp_coord(item.box_y2);

  // a flushing tick needs the snapshot slot free or draining
  assign emits = (item.kind == dst_pkg::KIND_TICK) && (tick_count == dst_pkg::TICK_LAST)
                 && damage_pending;
  assign item_retire = item_valid && (!emits || !snap_valid || snap_take);

  // damage state, tick counter and snapshot slot
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x        <= '0;
      start_y        <= '0;
      end_x          <= '0;
      end_y          <= '0;
      damage_pending <= 1'b0;
      tick_count     <= '0;
      snap_valid     <= 1'b0;
    end else begin
      if (item_retire && emits) begin
        snap_valid <= 1'b1;
      end else if (snap_take) begin
        snap_valid <= 1'b0;
      end
      if (item_retire) begin
        if (item.kind == dst_pkg::KIND_BOX) begin
          if (!damage_pending) begin
            start_x        <= x1_c;
            start_y        <= y1_c;
            end_x          <= x2_c;
            end_y          <= y2_c;
            damage_pending <= 1'b1;
          end else begin
            if (y1_c < start_y) begin
              start_y <= y1_c;
              start_x <= x1_c;
            end else if (y1_c == start_y && x1_c < start_x) begin
              start_x <= x1_c;
            end
            if (y2_c > end_y) begin
              end_y <= y2_c;
              end_x <= x2_c;
            end else if (y2_c == end_y && x2_c > end_x) begin
              end_x <= x2_c;
            end
          end
        end else if (tick_count != dst_pkg::TICK_LAST) begin
          tick_count <= tick_count + 2'd1;
        end else begin
          tick_count <= '0;
          if (damage_pending) begin
            damage_pending <= 1'b0;
            snap.start_x   <= start_x;
            snap.start_y   <= start_y;
            snap.rows_m1   <= $signed({2'b00, end_y}) - $signed({2'b00, start_y})
                              - 15'sd1;
            snap.cols      <= $signed({1'b0, end_x}) - $signed({1'b0, start_x});
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/dst_span_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

module dst_span_calc (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [14:0]         row_pitch,
  input  wire logic [2:0]          bytes_per_pixel,
  input  wire logic                snap_valid,
  input  wire dst_pkg::span_snap_t snap,
  output logic                     snap_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dst_pkg::span_result_t    out_item
);

  logic [27:0]        off_rows;
  logic [15:0]        off_cols;
  logic [28:0]        off_sum;
  logic signed [30:0] len_rows;
  logic signed [17:0] len_cols;
  logic signed [31:0] len_sum;
  logic [26:0]        off_sat;
  logic [26:0]        len_sat;

  // byte offset of span start
  assign off_rows = snap.start_y * row_pitch;
  assign off_cols = snap.start_x * bytes_per_pixel;
  assign off_sum  = 29'(off_rows) + 29'(off_cols);
  assign off_sat  = (|off_sum[28:27]) ? dst_pkg::OUT_MAX : off_sum[26:0];

  // byte length, clipped to zero when negative and to OUT_MAX when too large
  assign len_rows = snap.rows_m1 * $signed({1'b0, row_pitch});
  assign len_cols = snap.cols * $signed({1'b0, bytes_per_pixel});
  assign len_sum  = 32'(len_rows) + 32'(len_cols);

  always_comb begin
    if (len_sum[31]) begin
      len_sat = '0;
    end else if (|len_sum[30:27]) begin
      len_sat = dst_pkg::OUT_MAX;
    end else begin
      len_sat = len_sum[26:0];
    end
  end

  assign snap_take = snap_valid && (!out_valid || !out_stall);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid             <= 1'b1;
      out_item.start_offset <= off_sat;
      out_item.span_length  <= len_sat;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/dirty_span_tracker.sv */
// a flushing tick passes through the input register, the snapshot slot and the result register
// throughput: one request per cycle, boxes and ticks alike, while in_stall is low
// a held result stalls requests only when a further flush also needs the result path
// reset (synchronous): span, pending flag and tick counter cleared, pipeline emptied,
// row pitch back to 4096 and bytes per pixel back to 2
`timescale 1ns / 1ps
`default_nettype none

module dirty_span_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire dst_pkg::box_item_t    in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output dst_pkg::span_result_t      out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [14:0]           cfg_data
);

  logic                row_valid;
  dst_pkg::box_item_t  row_item;
  logic                row_retire;
  logic [14:0]         row_pitch;
  logic [2:0]          bytes_per_pixel;
  logic                snap_valid;
  logic                snap_take;
  dst_pkg::span_snap_t snap;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch       <= dst_pkg::ROW_PITCH_RESET;
      bytes_per_pixel <= dst_pkg::BYTES_PER_PIXEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dst_pkg::REG_ROW_PITCH:       row_pitch       <= cfg_data;
        dst_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // input register
  assign in_stall = row_valid && !row_retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      row_valid <= 1'b1;
      row_item  <= in_item;
    end else if (row_retire) begin
      row_valid <= 1'b0;
    end
  end

  dst_span_update u_update (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (row_valid),
    .item        (row_item),
    .item_retire (row_retire),
    .snap_valid  (snap_valid),
    .snap_take   (snap_take),
    .snap        (snap)
  );

  dst_span_calc u_calc (
    .clk             (clk),
    .rst             (rst),
    .row_pitch       (row_pitch),
    .bytes_per_pixel (bytes_per_pixel),
    .snap_valid      (snap_valid),
    .snap            (snap),
    .snap_take       (snap_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item)
  );

  // a waiting snapshot is never lost
  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_take |=> snap_valid)
    else $error("span snapshot dropped while waiting");

  // a snapshot taken always shows up as a result
  a_snap_to_out: assert property (@(posedge clk) disable iff (rst)
    snap_take |=> out_valid)
    else $error("span snapshot taken without a result");

  // requests are only held back by a full input register
  a_stall_needs_row: assert property (@(posedge clk) disable iff (rst)
    !row_valid |-> !in_stall)
    else $error("request stalled with empty input register");

endmodule

`default_nettype wire
